/* sv/indexed_sequential_list_top_defines.svh */
// ----------------------------------------------------------------------------
// Indexed sequential list assertion macros
// Shared property forms for the list block checks.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENTIAL_LIST_TOP_DEFINES_SVH
`define INDEXED_SEQUENTIAL_LIST_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ISL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("isl check failed");

// Next-cycle implication, disabled during reset.
`define ISL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("isl check failed");

`endif

/* sv/isl_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed sequential list package
// Operation and status codes, sequencer states and scan unit control.
// ----------------------------------------------------------------------------
package isl_pkg;

    typedef enum logic [3:0] {
        OP_INSERT  = 4'd0,
        OP_APPEND  = 4'd1,
        OP_REMOVE  = 4'd2,
        OP_UPDATE  = 4'd3,
        OP_READ    = 4'd4,
        OP_SWAP    = 4'd5,
        OP_REVERSE = 4'd6,
        OP_COUNT   = 4'd7,
        OP_MAX     = 4'd8,
        OP_MIN     = 4'd9,
        OP_CLEAR   = 4'd10
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_REM,
        S_RD,
        S_PA,
        S_PB,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic clear;
        logic valid;
        t_op  op;
    } t_scan_ctl;

endpackage

/* sv/isl_scan_unit.sv */
// ----------------------------------------------------------------------------
// Indexed sequential list scan unit
// Shared compare unit: match count, running maximum or running minimum.
// ----------------------------------------------------------------------------
module isl_scan_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  isl_pkg::t_scan_ctl i_ctl,
    input  logic signed [31:0] i_elem,
    input  logic signed [31:0] i_value,
    output logic signed [31:0] o_next
);
    import isl_pkg::*;

    logic signed [31:0] r_acc;
    logic signed [31:0] n_acc;
    logic               r_have;
    logic               n_have;

    always_comb begin
        n_acc  = r_acc;
        n_have = r_have;
        if (i_ctl.clear) begin
            n_acc  = 32'sd0;
            n_have = 1'b0;
        end else if (i_ctl.valid) begin
            n_have = 1'b1;
            case (i_ctl.op)
                OP_COUNT: begin
                    if (i_elem == i_value) begin
                        n_acc = r_acc + 32'sd1;
                    end
                end
                OP_MAX: begin
                    if (!r_have || (i_elem > r_acc)) begin
                        n_acc = i_elem;
                    end
                end
                OP_MIN: begin
                    if (!r_have || (i_elem < r_acc)) begin
                        n_acc = i_elem;
                    end
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else begin
            r_have <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_next = n_acc;

endmodule

/* sv/indexed_sequential_list_top.sv */
// ----------------------------------------------------------------------------
// Indexed sequential list
// A one-based list of signed 32-bit words in an on-chip store with insert,
// append, remove, update, read, swap, reverse, count, max, min and clear.
// ----------------------------------------------------------------------------
// Append, update, clear, unused codes, errors, tail insert or remove, reverse
// under two elements and scans of an empty list strobe in the cycle after
// start; read, swap, insert, remove, reverse, count, max and min pass through
// further states first. Throughput: one word at a time; the element walk
// touches one element per cycle. Reset (synchronous, active low) empties the
// list; results cannot be stalled.
`include "indexed_sequential_list_top_defines.svh"

module indexed_sequential_list_top #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_operation,
    input  logic [6:0]         i_position,
    input  logic [6:0]         i_position_b,
    input  logic signed [31:0] i_value,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_data,
    output logic [6:0]         o_list_length
);
    import isl_pkg::*;

    // Address width, length width, and a compare width that holds both a
    // position and a length plus one.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int PW = ((LW > 7) ? LW : 7) + 1;

    // Element store: one write port, two registered read ports.
    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] r_rd_a;
    logic signed [31:0] r_rd_b;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [31:0] mem_wd;
    logic               mem_rea;
    logic [AW-1:0]      mem_ra;
    logic               mem_reb;
    logic [AW-1:0]      mem_rb;

    // Sequencer registers.
    t_state             r_state;
    t_state             n_state;
    t_op                r_op;
    t_op                n_op;
    logic signed [31:0] r_val;
    logic signed [31:0] n_val;
    logic [LW-1:0]      r_len;
    logic [LW-1:0]      n_len;
    logic [AW-1:0]      r_wa;
    logic [AW-1:0]      n_wa;
    logic [AW-1:0]      r_wb;
    logic [AW-1:0]      n_wb;
    logic [LW-1:0]      r_cnt;
    logic [LW-1:0]      n_cnt;

    // Result word.
    logic               r_strobe;
    t_status            r_status;
    logic signed [31:0] r_data;
    logic               fin;
    t_status            fin_status;
    logic signed [31:0] fin_data;

    // Scan unit hookup.
    t_scan_ctl          scan_ctl;
    logic signed [31:0] scan_next;

    // Decode of the incoming word against the current length.
    t_op                in_op;
    logic               accept;
    logic [PW-1:0]      len_p;
    logic [PW-1:0]      pa_p;
    logic [PW-1:0]      pb_p;
    logic               pa_in;
    logic               pb_in;
    logic               pa_ins;
    logic               full;
    logic [AW-1:0]      pa_m1;
    logic [AW-1:0]      pb_m1;
    logic [LW-1:0]      ins_moves;
    logic [LW-1:0]      rem_moves;
    logic               last;

    assign in_op     = t_op'(i_operation);
    assign accept    = start && (r_state == S_IDLE);
    assign len_p     = PW'(r_len);
    assign pa_p      = PW'(i_position);
    assign pb_p      = PW'(i_position_b);
    assign pa_in     = (pa_p != '0) && (pa_p <= len_p);
    assign pb_in     = (pb_p != '0) && (pb_p <= len_p);
    assign pa_ins    = (pa_p != '0) && (pa_p <= (len_p + PW'(1)));
    assign full      = (r_len == LW'(CAPACITY));
    assign pa_m1     = AW'(pa_p - PW'(1));
    assign pb_m1     = AW'(pb_p - PW'(1));
    assign ins_moves = LW'(len_p - pa_p + PW'(1));
    assign rem_moves = LW'(len_p - pa_p);
    assign last      = (r_cnt == LW'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (in_op)
                        OP_INSERT: begin
                            if (pa_ins && !full && (ins_moves != '0)) begin
                                n_state = S_INS;
                            end
                        end
                        OP_REMOVE: begin
                            if (pa_in && (rem_moves != '0)) begin
                                n_state = S_REM;
                            end
                        end
                        OP_READ: begin
                            if (pa_in) begin
                                n_state = S_RD;
                            end
                        end
                        OP_SWAP: begin
                            if (pa_in && pb_in) begin
                                n_state = S_PA;
                            end
                        end
                        OP_REVERSE: begin
                            if (r_len >= LW'(2)) begin
                                n_state = S_PA;
                            end
                        end
                        OP_COUNT, OP_MAX, OP_MIN: begin
                            if (r_len != '0) begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS:   n_state = last ? S_PUT : S_INS;
            S_PUT:   n_state = S_IDLE;
            S_REM:   n_state = last ? S_IDLE : S_REM;
            S_RD:    n_state = S_IDLE;
            S_PA:    n_state = S_PB;
            S_PB:    n_state = last ? S_IDLE : S_PA;
            S_SCAN:  n_state = last ? S_IDLE : S_SCAN;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, store and result control.
    always_comb begin
        n_op       = r_op;
        n_val      = r_val;
        n_len      = r_len;
        n_wa       = r_wa;
        n_wb       = r_wb;
        n_cnt      = r_cnt;
        mem_we     = 1'b0;
        mem_wa     = r_wa;
        mem_wd     = r_rd_a;
        mem_rea    = 1'b0;
        mem_ra     = r_wa;
        mem_reb    = 1'b0;
        mem_rb     = r_wb;
        fin        = 1'b0;
        fin_status = ST_OK;
        fin_data   = 32'sd0;
        scan_ctl   = '{clear: 1'b0, valid: 1'b0, op: r_op};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op           = in_op;
                    n_val          = i_value;
                    scan_ctl.clear = 1'b1;
                    case (in_op)
                        OP_INSERT: begin
                            if (!pa_ins) begin
                                fin        = 1'b1;
                                fin_status = ST_ILLEGAL;
                            end else if (full) begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end else if (ins_moves == '0) begin
                                // Insert at the tail: no shift needed.
                                mem_we = 1'b1;
                                mem_wa = pa_m1;
                                mem_wd = i_value;
                                n_len  = r_len + LW'(1);
                                fin    = 1'b1;
                            end else begin
                                // Start the backward shift at the last element.
                                mem_rea = 1'b1;
                                mem_ra  = AW'(r_len - LW'(1));
                                n_wa    = AW'(r_len);
                                n_cnt   = ins_moves;
                            end
                        end
                        OP_APPEND: begin
                            fin = 1'b1;
                            if (full) begin
                                fin_status = ST_FULL;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = AW'(r_len);
                                mem_wd = i_value;
                                n_len  = r_len + LW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            if (!pa_in) begin
                                fin        = 1'b1;
                                fin_status = ST_ILLEGAL;
                            end else if (rem_moves == '0) begin
                                n_len = r_len - LW'(1);
                                fin   = 1'b1;
                            end else begin
                                mem_rea = 1'b1;
                                mem_ra  = AW'(pa_p);
                                n_wa    = pa_m1;
                                n_cnt   = rem_moves;
                            end
                        end
                        OP_UPDATE: begin
                            fin = 1'b1;
                            if (!pa_in) begin
                                fin_status = ST_ILLEGAL;
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = pa_m1;
                                mem_wd = i_value;
                            end
                        end
                        OP_READ: begin
                            if (!pa_in) begin
                                fin        = 1'b1;
                                fin_status = ST_ILLEGAL;
                            end else begin
                                mem_rea = 1'b1;
                                mem_ra  = pa_m1;
                            end
                        end
                        OP_SWAP: begin
                            if (!(pa_in && pb_in)) begin
                                fin        = 1'b1;
                                fin_status = ST_ILLEGAL;
                            end else begin
                                mem_rea = 1'b1;
                                mem_ra  = pa_m1;
                                mem_reb = 1'b1;
                                mem_rb  = pb_m1;
                                n_wa    = pa_m1;
                                n_wb    = pb_m1;
                                n_cnt   = LW'(1);
                            end
                        end
                        OP_REVERSE: begin
                            if (r_len < LW'(2)) begin
                                fin = 1'b1;
                            end else begin
                                // Pair the outermost elements and walk inward.
                                mem_rea = 1'b1;
                                mem_ra  = '0;
                                mem_reb = 1'b1;
                                mem_rb  = AW'(r_len - LW'(1));
                                n_wa    = '0;
                                n_wb    = AW'(r_len - LW'(1));
                                n_cnt   = r_len >> 1;
                            end
                        end
                        OP_COUNT, OP_MAX, OP_MIN: begin
                            if (r_len == '0) begin
                                fin = 1'b1;
                            end else begin
                                mem_rea = 1'b1;
                                mem_ra  = '0;
                                n_wa    = AW'(1);
                                n_cnt   = r_len;
                            end
                        end
                        OP_CLEAR: begin
                            n_len = '0;
                            fin   = 1'b1;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_INS: begin
                // Move one element up; prefetch the one below.
                mem_we = 1'b1;
                mem_wa = r_wa;
                mem_wd = r_rd_a;
                n_wa   = r_wa - AW'(1);
                n_cnt  = r_cnt - LW'(1);
                if (!last) begin
                    mem_rea = 1'b1;
                    mem_ra  = r_wa - AW'(2);
                end
            end
            S_PUT: begin
                mem_we = 1'b1;
                mem_wa = r_wa;
                mem_wd = r_val;
                n_len  = r_len + LW'(1);
                fin    = 1'b1;
            end
            S_REM: begin
                // Move one element down; prefetch the one above.
                mem_we = 1'b1;
                mem_wa = r_wa;
                mem_wd = r_rd_a;
                n_wa   = r_wa + AW'(1);
                n_cnt  = r_cnt - LW'(1);
                if (!last) begin
                    mem_rea = 1'b1;
                    mem_ra  = r_wa + AW'(2);
                end else begin
                    n_len = r_len - LW'(1);
                    fin   = 1'b1;
                end
            end
            S_RD: begin
                fin      = 1'b1;
                fin_data = r_rd_a;
            end
            S_PA: begin
                mem_we = 1'b1;
                mem_wa = r_wa;
                mem_wd = r_rd_b;
            end
            S_PB: begin
                mem_we = 1'b1;
                mem_wa = r_wb;
                mem_wd = r_rd_a;
                if (!last) begin
                    mem_rea = 1'b1;
                    mem_ra  = r_wa + AW'(1);
                    mem_reb = 1'b1;
                    mem_rb  = r_wb - AW'(1);
                    n_wa    = r_wa + AW'(1);
                    n_wb    = r_wb - AW'(1);
                    n_cnt   = r_cnt - LW'(1);
                end else begin
                    fin = 1'b1;
                end
            end
            S_SCAN: begin
                scan_ctl.valid = 1'b1;
                n_cnt          = r_cnt - LW'(1);
                if (!last) begin
                    mem_rea = 1'b1;
                    mem_ra  = r_wa;
                    n_wa    = r_wa + AW'(1);
                end else begin
                    fin      = 1'b1;
                    fin_data = scan_next;
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_strobe <= fin;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_val <= n_val;
        r_wa  <= n_wa;
        r_wb  <= n_wb;
        r_cnt <= n_cnt;
        if (fin) begin
            r_status <= fin_status;
            r_data   <= fin_data;
        end
    end

    // Element store.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_rea) begin
            r_rd_a <= mem[mem_ra];
        end
        if (mem_reb) begin
            r_rd_b <= mem[mem_rb];
        end
    end

    isl_scan_unit u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_elem  (r_rd_a),
        .i_value (r_val),
        .o_next  (scan_next)
    );

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_data        = r_data;
    assign o_list_length = 7'(r_len);

    // Checks.
    `ISL_ASSERT_SAME(a_len_cap, i_clk, i_rst_n, 1'b1, r_len <= LW'(CAPACITY))
    `ISL_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, r_strobe, r_state == S_IDLE)
    `ISL_ASSERT_SAME(a_full_len, i_clk, i_rst_n,
        r_strobe && (r_status == ST_FULL), r_len == LW'(CAPACITY))
    `ISL_ASSERT_NEXT(a_accept_acts, i_clk, i_rst_n, accept, r_strobe || (r_state != S_IDLE))

endmodule

/* tb/sv/indexed_sequential_list_top_test.sv */
// ----------------------------------------------------------------------------
// Indexed sequential list testbench
// Drives list operations through the start/busy handshake, first from a short
// table of corner cases and then from random fill and drain sequences, and
// checks every strobed result against a row expectation or a behavioral list.
// ----------------------------------------------------------------------------
module indexed_sequential_list_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import isl_pkg::*;

    localparam int          CAPACITY     = 64;
    localparam int          CLK_PERIOD   = 4;
    localparam int          RESET_CYCLES = 8;
    localparam int          RANDOM_WORDS = 1850;
    // No idling at all over the closing stretch of the random part.
    localparam int          QUIET_TAIL   = 200;
    // Longest operation walks the whole store.
    localparam int          DRAIN_CYCLES = CAPACITY + 8;
    localparam logic [3:0]  OP_UNUSED_LO = 4'(OP_CLEAR) + 4'd1;
    localparam logic [3:0]  OP_UNUSED_HI = 4'hF;
    localparam logic [6:0]  POS_TOP      = 7'h7F;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_ONES = -32'sd1;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data;
        logic [6:0]         length;
    } t_list_result;

    typedef struct packed {
        logic [3:0]         op;
        logic [6:0]         pos;
        logic [6:0]         pos_b;
        logic signed [31:0] value;
        logic               typed;
        t_list_result       want;
    } t_stim_row;

    localparam t_list_result NO_WANT = '{ST_OK, 32'sd0, 7'd0};

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         i_operation;
    logic [6:0]         i_position;
    logic [6:0]         i_position_b;
    logic signed [31:0] i_value;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic signed [31:0] o_data;
    logic [6:0]         o_list_length;

    indexed_sequential_list_top #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_position_b (i_position_b),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_data       (o_data),
        .o_list_length(o_list_length)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Bench copy of the list and the results still owed by the block
    // ------------------------------------------------------------------------
    logic signed [31:0] list_words [CAPACITY];
    int                 list_len;
    t_list_result       awaited_results [$];
    int                 mismatch_count;
    bit                 idle_allowed;
    bit                 filling;

    // Directed corner cases. Rows with typed set carry an expectation that can
    // be read straight off the list contents; the rest fall to the predictor.
    t_stim_row corner_rows [25] = '{
        // empty list: every positional access is illegal, scans give zero
        '{OP_READ,    7'd1, 7'd0, 32'sd0,   1'b1, '{ST_ILLEGAL, 32'sd0, 7'd0}},
        '{OP_MAX,     7'd0, 7'd0, 32'sd0,   1'b1, '{ST_OK,      32'sd0, 7'd0}},
        '{OP_MIN,     7'd0, 7'd0, 32'sd0,   1'b1, '{ST_OK,      32'sd0, 7'd0}},
        '{OP_REMOVE,  7'd1, 7'd0, 32'sd0,   1'b1, '{ST_ILLEGAL, 32'sd0, 7'd0}},
        // insert range is 1..len+1
        '{OP_INSERT,  7'd0, 7'd0, 32'sd5,   1'b1, '{ST_ILLEGAL, 32'sd0, 7'd0}},
        '{OP_INSERT,  7'd2, 7'd0, 32'sd5,   1'b1, '{ST_ILLEGAL, 32'sd0, 7'd0}},
        '{OP_INSERT,  7'd1, 7'd0, WORD_MAX, 1'b1, '{ST_OK,      32'sd0, 7'd1}},
        '{OP_APPEND,  7'd0, 7'd0, WORD_MIN, 1'b1, '{ST_OK,      32'sd0, 7'd2}},
        '{OP_INSERT,  7'd3, 7'd0, WORD_ONES, 1'b1, '{ST_OK,     32'sd0, 7'd3}},
        '{OP_INSERT,  7'd2, 7'd0, 32'sd7,   1'b0, NO_WANT},
        // list is now MAX, 7, MIN, -1
        '{OP_READ,    7'd4, 7'd0, 32'sd0,   1'b1, '{ST_OK,      WORD_ONES, 7'd4}},
        '{OP_MAX,     7'd0, 7'd0, 32'sd0,   1'b1, '{ST_OK,      WORD_MAX, 7'd4}},
        '{OP_MIN,     7'd0, 7'd0, 32'sd0,   1'b1, '{ST_OK,      WORD_MIN, 7'd4}},
        '{OP_COUNT,   7'd0, 7'd0, WORD_ONES, 1'b1, '{ST_OK,     32'sd1, 7'd4}},
        // swap checks both positions
        '{OP_SWAP,    7'd1, 7'd5, 32'sd0,   1'b1, '{ST_ILLEGAL, 32'sd0, 7'd4}},
        '{OP_SWAP,    7'd0, 7'd2, 32'sd0,   1'b1, '{ST_ILLEGAL, 32'sd0, 7'd4}},
        '{OP_SWAP,    7'd1, 7'd4, 32'sd0,   1'b0, NO_WANT},
        '{OP_REVERSE, 7'd0, 7'd0, 32'sd0,   1'b0, NO_WANT},
        '{OP_UPDATE,  7'd5, 7'd0, 32'sd9,   1'b1, '{ST_ILLEGAL, 32'sd0, 7'd4}},
        '{OP_UPDATE,  7'd2, 7'd0, 32'sd0,   1'b0, NO_WANT},
        '{OP_REMOVE,  7'd1, 7'd0, 32'sd0,   1'b0, NO_WANT},
        '{OP_READ,    POS_TOP, 7'd0, 32'sd0, 1'b1, '{ST_ILLEGAL, 32'sd0, 7'd3}},
        // unused code: no change, all fields at their top values
        '{OP_UNUSED_HI, POS_TOP, POS_TOP, WORD_ONES, 1'b1, '{ST_OK, 32'sd0, 7'd3}},
        '{OP_CLEAR,   7'd0, 7'd0, 32'sd0,   1'b1, '{ST_OK,      32'sd0, 7'd0}},
        '{OP_COUNT,   7'd0, 7'd0, 32'sd0,   1'b1, '{ST_OK,      32'sd0, 7'd0}}
    };

    // ------------------------------------------------------------------------
    // Predictor: apply one word to the bench list and return its result
    // ------------------------------------------------------------------------
    function automatic t_list_result apply_list_word(input logic [3:0] op,
                                                     input logic [6:0] pos,
                                                     input logic [6:0] pos_b,
                                                     input logic signed [31:0] val);
        t_list_result       res;
        int                 n;
        int                 pa;
        int                 pb;
        logic signed [31:0] held;
        n = list_len;
        pa = pos;
        pb = pos_b;
        res = '{ST_OK, 32'sd0, 7'd0};
        case (op)
            OP_INSERT: begin
                if (pa < 1 || pa > n + 1) begin
                    res.status = ST_ILLEGAL;
                end else if (n >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = n; i >= pa; i--) list_words[i] = list_words[i-1];
                    list_words[pa-1] = val;
                    list_len = n + 1;
                end
            end
            OP_APPEND: begin
                if (n >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    list_words[n] = val;
                    list_len = n + 1;
                end
            end
            OP_REMOVE: begin
                if (pa < 1 || pa > n) begin
                    res.status = ST_ILLEGAL;
                end else begin
                    for (int i = pa; i < n; i++) list_words[i-1] = list_words[i];
                    list_len = n - 1;
                end
            end
            OP_UPDATE: begin
                if (pa < 1 || pa > n) res.status = ST_ILLEGAL;
                else list_words[pa-1] = val;
            end
            OP_READ: begin
                if (pa < 1 || pa > n) res.status = ST_ILLEGAL;
                else res.data = list_words[pa-1];
            end
            OP_SWAP: begin
                if (pa < 1 || pa > n || pb < 1 || pb > n) begin
                    res.status = ST_ILLEGAL;
                end else begin
                    held = list_words[pa-1];
                    list_words[pa-1] = list_words[pb-1];
                    list_words[pb-1] = held;
                end
            end
            OP_REVERSE: begin
                for (int i = 0; i < n / 2; i++) begin
                    held = list_words[i];
                    list_words[i] = list_words[n-1-i];
                    list_words[n-1-i] = held;
                end
            end
            OP_COUNT: begin
                for (int i = 0; i < n; i++)
                    if (list_words[i] == val) res.data = res.data + 32'sd1;
            end
            OP_MAX: begin
                if (n > 0) res.data = list_words[0];
                for (int i = 1; i < n; i++)
                    if (list_words[i] > res.data) res.data = list_words[i];
            end
            OP_MIN: begin
                if (n > 0) res.data = list_words[0];
                for (int i = 1; i < n; i++)
                    if (list_words[i] < res.data) res.data = list_words[i];
            end
            OP_CLEAR: begin
                list_len = 0;
            end
            default: begin
            end
        endcase
        res.length = 7'(list_len);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: optionally idle, present one word, hold it until accepted
    // ------------------------------------------------------------------------
    task automatic send_list_word(input logic [3:0] op, input logic [6:0] pos,
                                  input logic [6:0] pos_b,
                                  input logic signed [31:0] val,
                                  input logic typed, input t_list_result want);
        t_list_result predicted;
        // Drop start for a burst now and then so gaps land on every phase.
        if (idle_allowed && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_operation  <= op;
        i_position   <= pos;
        i_position_b <= pos_b;
        i_value      <= val;
        // Busy read right after the edge is its value before that edge.
        do @(posedge i_clk); while (busy);
        predicted = apply_list_word(op, pos, pos_b, val);
        awaited_results.push_back(typed ? want : predicted);
    endtask

    // Value mix: raw random, extremes, or a word already in the list so that
    // counts and duplicates show up.
    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) return $urandom;
        if (sel < 6) begin
            case ($urandom_range(0, 4))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return WORD_ONES;
                3: return 32'sd1;
                default: return 32'sd0;
            endcase
        end
        if (list_len > 0) return list_words[$urandom_range(0, list_len - 1)];
        return $urandom;
    endfunction

    // Mostly legal positions; the rest span the whole 7-bit field.
    function automatic logic [6:0] pick_position(input int legal_top);
        if (legal_top >= 1 && $urandom_range(0, 99) < 85)
            return 7'($urandom_range(1, legal_top));
        return 7'($urandom_range(0, 127));
    endfunction

    // Random word shaped as fill/drain sequences over the whole capacity.
    task automatic send_random_word();
        int         roll;
        logic [3:0] op;
        // Switch direction at the ends, lingering a while at full.
        if (filling && list_len == CAPACITY && $urandom_range(0, 7) == 0) filling = 1'b0;
        if (!filling && list_len <= 2 && $urandom_range(0, 3) == 0) filling = 1'b1;
        roll = $urandom_range(0, 99);
        if (filling) begin
            if      (roll < 35) op = OP_APPEND;
            else if (roll < 60) op = OP_INSERT;
            else if (roll < 64) op = OP_REMOVE;
            else if (roll < 69) op = OP_UPDATE;
            else if (roll < 74) op = OP_READ;
            else if (roll < 79) op = OP_SWAP;
            else if (roll < 83) op = OP_REVERSE;
            else if (roll < 88) op = OP_COUNT;
            else if (roll < 91) op = OP_MAX;
            else if (roll < 94) op = OP_MIN;
            else if (roll < 95) op = OP_CLEAR;
            else if (roll < 98) op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else                op = OP_APPEND;
        end else begin
            if      (roll < 40) op = OP_REMOVE;
            else if (roll < 45) op = OP_INSERT;
            else if (roll < 50) op = OP_APPEND;
            else if (roll < 57) op = OP_UPDATE;
            else if (roll < 64) op = OP_READ;
            else if (roll < 71) op = OP_SWAP;
            else if (roll < 76) op = OP_REVERSE;
            else if (roll < 83) op = OP_COUNT;
            else if (roll < 88) op = OP_MAX;
            else if (roll < 93) op = OP_MIN;
            else if (roll < 96) op = OP_CLEAR;
            else                op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
        send_list_word(op,
                       pick_position(op == OP_INSERT ? list_len + 1 : list_len),
                       op == OP_SWAP ? pick_position(list_len)
                                     : 7'($urandom_range(0, 127)),
                       pick_value(), 1'b0, NO_WANT);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_operation    <= '0;
        i_position     <= '0;
        i_position_b   <= '0;
        i_value        <= '0;
        list_len       = 0;
        mismatch_count = 0;
        idle_allowed   = 1'b1;
        filling        = 1'b1;
        for (int i = 0; i < CAPACITY; i++) list_words[i] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_rows[r])
            send_list_word(corner_rows[r].op, corner_rows[r].pos, corner_rows[r].pos_b,
                           corner_rows[r].value, corner_rows[r].typed, corner_rows[r].want);

        for (int w = 0; w < RANDOM_WORDS; w++) begin
            // Alternate idling and back-to-back stretches; none in the tail.
            if (w % 40 == 0) idle_allowed = $urandom_range(0, 2) != 0;
            if (w >= RANDOM_WORDS - QUIET_TAIL) idle_allowed = 1'b0;
            send_random_word();
        end
        start <= 1'b0;

        // Wait for every owed result, then watch a little longer for strays.
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result checker: one strobe, one word, matched against the oldest owed
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d data=%0d length=%0d",
                         $time, o_status, o_data, o_list_length);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    mismatch_count++;
                end
                if (o_data !== want.data) begin
                    $display("%0t: data expected %0d actual %0d", $time, want.data, o_data);
                    mismatch_count++;
                end
                if (o_list_length !== want.length) begin
                    $display("%0t: list_length expected %0d actual %0d",
                             $time, want.length, o_list_length);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
